[sv/smia_pkg.sv]
// Shared constants, codes and pipeline types for the stack machine integer ALU.
package smia_pkg;

   localparam int DATA_WIDTH = 64;
   localparam int HALF_WIDTH = DATA_WIDTH / 2;
   localparam int SHIFT_BITS = $clog2(DATA_WIDTH);
   localparam int DIV_STAGES = DATA_WIDTH;

   localparam logic [3:0] CMD_ADD  = 4'd0;
   localparam logic [3:0] CMD_SUB  = 4'd1;
   localparam logic [3:0] CMD_MUL  = 4'd2;
   localparam logic [3:0] CMD_DIV  = 4'd3;
   localparam logic [3:0] CMD_MOD  = 4'd4;
   localparam logic [3:0] CMD_UMUL = 4'd5;
   localparam logic [3:0] CMD_UDIV = 4'd6;
   localparam logic [3:0] CMD_NAND = 4'd7;
   localparam logic [3:0] CMD_SHL  = 4'd8;
   localparam logic [3:0] CMD_SHR  = 4'd9;
   localparam logic [3:0] CMD_EQ   = 4'd10;

   localparam logic [1:0] KIND_INT  = 2'd0;
   localparam logic [1:0] KIND_NIL  = 2'd1;
   localparam logic [1:0] KIND_TRUE = 2'd2;

   typedef logic [DATA_WIDTH-1:0] word_type;

   // One slot of the divider pipeline, with the side data that rides along.
   typedef struct packed {
      word_type   rem;
      word_type   quo;
      word_type   dvs;
      word_type   res;
      word_type   rhs;
      logic [1:0] kind;
      logic       op_div;
      logic       op_mod;
      logic       op_udiv;
      logic       neg_a;
      logic       neg_b;
   } pipe_type;

   // One restoring division step: shift in a dividend bit, try the subtract.
   function automatic pipe_type div_step(pipe_type p);
      pipe_type              r;
      logic [DATA_WIDTH:0]   t;
      logic [DATA_WIDTH:0]   diff;
      r    = p;
      t    = {p.rem, p.quo[DATA_WIDTH-1]};
      diff = t - {1'b0, p.dvs};
      if (!diff[DATA_WIDTH]) begin
         r.rem = diff[DATA_WIDTH-1:0];
         r.quo = {p.quo[DATA_WIDTH-2:0], 1'b1};
      end else begin
         r.rem = t[DATA_WIDTH-1:0];
         r.quo = {p.quo[DATA_WIDTH-2:0], 1'b0};
      end
      return r;
   endfunction

endpackage

[sv/stack_machine_integer_alu.sv]
// Top level: pipelined integer ALU with a one-bit-per-stage divider.
//
// Usage:
//   Input words arrive on req_*: req_tdata carries the two operands, req_tuser
//   the command and the two is-integer tags. Each accepted word yields exactly
//   one result word on rsp_*: rsp_tdata holds the 64-bit value, rsp_tuser the
//   kind (integer, nil or true).
//   Every command runs through the same pipeline so results leave in order:
//   input register, decode/partial-product stage, DATA_WIDTH divider stages
//   (one quotient bit each) and the output register.
//   Throughput is one word per cycle while the output register is empty or rsp_tready is high.
//   Reset clears all valid bits; no result is pending afterward.
//   When the receiver holds rsp_tready low with a result waiting, the whole
//   pipeline freezes and req_tready drops; nothing is lost or repeated, and
//   words keep entering while the output register is empty.
module stack_machine_integer_alu (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [127:0] req_tdata,  // top_value[63:0], next_value[127:64]
   input  logic [5:0]   req_tuser,  // command[3:0], top_is_int[4], next_is_int[5]
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [63:0]  rsp_tdata,  // value[63:0]
   output logic [1:0]   rsp_tuser   // kind[1:0]
);
   import smia_pkg::*;

   logic advance;

   // input stage
   logic       in_vld_ff, in_vld_in;
   logic [3:0] in_cmd_ff;
   word_type   in_a_ff, in_b_ff;
   logic       in_ok_ff;

   // decode stage
   logic       dec_vld_ff, dec_vld_in;
   pipe_type   dec_ff, dec_in;
   logic       dec_mul_ff, dec_mul_in;
   word_type   p0_ff, p0_in;
   logic [HALF_WIDTH-1:0] p1_ff, p1_in, p2_ff, p2_in;

   // divider stages
   logic     div_vld_ff [DIV_STAGES];
   logic     div_vld_in [DIV_STAGES];
   pipe_type div_ff [DIV_STAGES];
   pipe_type div_in [DIV_STAGES];

   // output register
   logic        out_vld_ff, out_vld_in;
   logic [63:0] out_val_ff, out_val_in;
   logic [1:0]  out_kind_ff, out_kind_in;

   assign advance    = !out_vld_ff || rsp_tready;
   assign req_tready = advance;
   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = out_val_ff;
   assign rsp_tuser  = out_kind_ff;

   assign in_vld_in = req_tvalid;

   // decode: simple ops finish here, divider operands and mul partials start
   always_comb begin
      word_type a, b, ma, mb;
      logic     na, nb, bz;
      a  = in_a_ff;
      b  = in_b_ff;
      na = a[DATA_WIDTH-1];
      nb = b[DATA_WIDTH-1];
      ma = na ? -a : a;
      mb = nb ? -b : b;
      bz = (b == '0);
      dec_vld_in = in_vld_ff;
      dec_mul_in = 1'b0;
      dec_in         = '0;
      dec_in.rhs     = b;
      dec_in.neg_a   = na;
      dec_in.neg_b   = nb;
      dec_in.kind    = KIND_INT;
      dec_in.quo     = ma;
      dec_in.dvs     = mb;
      p0_in = word_type'(a[HALF_WIDTH-1:0]) * word_type'(b[HALF_WIDTH-1:0]);
      p1_in = HALF_WIDTH'(a[HALF_WIDTH-1:0] * b[DATA_WIDTH-1:HALF_WIDTH]);
      p2_in = HALF_WIDTH'(a[DATA_WIDTH-1:HALF_WIDTH] * b[HALF_WIDTH-1:0]);
      if (!in_ok_ff) begin
         dec_in.kind = KIND_NIL;
      end else begin
         case (in_cmd_ff)
            CMD_ADD:  dec_in.res = a + b;
            CMD_SUB:  dec_in.res = a - b;
            CMD_MUL,
            CMD_UMUL: dec_mul_in = 1'b1;
            CMD_DIV: begin
               if (bz) dec_in.kind = KIND_NIL;
               else    dec_in.op_div = 1'b1;
            end
            CMD_MOD: begin
               if (bz) dec_in.kind = KIND_NIL;
               else    dec_in.op_mod = 1'b1;
            end
            CMD_UDIV: begin
               dec_in.quo = a;
               dec_in.dvs = b;
               if (bz) dec_in.kind = KIND_NIL;
               else    dec_in.op_udiv = 1'b1;
            end
            CMD_NAND: dec_in.res = ~(a & b);
            CMD_SHL: begin
               if (b >= word_type'(DATA_WIDTH)) dec_in.res = '0;
               else dec_in.res = a << b[SHIFT_BITS-1:0];
            end
            CMD_SHR: begin
               if (b >= word_type'(DATA_WIDTH)) dec_in.res = '0;
               else dec_in.res = a >> b[SHIFT_BITS-1:0];
            end
            CMD_EQ:  dec_in.kind = (a == b) ? KIND_TRUE : KIND_NIL;
            default: dec_in.kind = KIND_NIL;
         endcase
      end
   end

   // divider chain; the multiply partials are summed on entry
   always_comb begin
      pipe_type first;
      first = dec_ff;
      if (dec_mul_ff)
         first.res = p0_ff + {p1_ff + p2_ff, {HALF_WIDTH{1'b0}}};
      div_vld_in[0] = dec_vld_ff;
      div_in[0]     = div_step(first);
      for (int k = 1; k < DIV_STAGES; k++) begin
         div_vld_in[k] = div_vld_ff[k-1];
         div_in[k]     = div_step(div_ff[k-1]);
      end
   end

   // sign fix-up for div and floored mod; udiv takes the quotient as is
   always_comb begin
      pipe_type p;
      word_type r, m;
      p = div_ff[DIV_STAGES-1];
      r = p.res;
      m = p.rem;
      if (p.op_div) begin
         r = (p.neg_a != p.neg_b) ? -p.quo : p.quo;
      end else if (p.op_mod) begin
         r = p.neg_a ? -m : m;
         if (m != '0 && p.neg_a != p.neg_b) r = r + p.rhs;
      end else if (p.op_udiv) begin
         r = p.quo;
      end
      out_vld_in  = div_vld_ff[DIV_STAGES-1];
      out_kind_in = p.kind;
      out_val_in  = (p.kind == KIND_INT) ? 64'(signed'(r)) : 64'd0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         dec_vld_ff <= 1'b0;
         out_vld_ff <= 1'b0;
         for (int k = 0; k < DIV_STAGES; k++) div_vld_ff[k] <= 1'b0;
      end else if (advance) begin
         in_vld_ff  <= in_vld_in;
         dec_vld_ff <= dec_vld_in;
         out_vld_ff <= out_vld_in;
         for (int k = 0; k < DIV_STAGES; k++) div_vld_ff[k] <= div_vld_in[k];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         in_cmd_ff   <= req_tuser[3:0];
         in_b_ff     <= req_tdata[DATA_WIDTH-1:0];
         in_a_ff     <= req_tdata[64 +: DATA_WIDTH];
         in_ok_ff    <= req_tuser[4] & req_tuser[5];
         dec_ff      <= dec_in;
         dec_mul_ff  <= dec_mul_in;
         p0_ff       <= p0_in;
         p1_ff       <= p1_in;
         p2_ff       <= p2_in;
         out_val_ff  <= out_val_in;
         out_kind_ff <= out_kind_in;
         for (int k = 0; k < DIV_STAGES; k++) div_ff[k] <= div_in[k];
      end
   end

endmodule
